// File: hdl/hmng_pkg.sv
`timescale 1ns / 1ps
package hmng_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int SUM_W = 10;
    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic signed [15:0] BORDER_Y = 16'sd16384;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ROOT,
        ST_DIV,
        ST_OUT1,
        ST_OUT2
    } t_state;
endpackage

// File: hdl/height_map_normal_generator_core.sv
`timescale 1ns / 1ps
// Channel  | direction | handshake                      | payload
// cfg      | in        | i_cfg_we                       | i_cfg_index, i_cfg_data
// pixel    | in        | i_valid / o_stall              | i_red, i_green, i_blue
// normal   | out       | o_valid / i_stall              | o_column .. o_last
//
// One pixel at a time: a pixel with no result passes READ only, one with a border result
// adds OUT1, and the bottom row adds OUT2 for its second result. An interior pixel runs
// the bit-serial square root and then the shared restoring divider (three 30-bit
// numerators, 6 bits per cycle) before OUT1, and takes OUT2 if it closes the bottom row.
// Reset (synchronous, active low) clears the counters and the registers to
// 1024 x 1024; the line stores are not cleared. A stalled output holds its beat.
module height_map_normal_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_column,
    output logic [15:0] o_row,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic        o_is_border,
    output logic        o_last
);
    localparam int CW = hmng_pkg::COL_W;
    localparam int SW = hmng_pkg::SUM_W;

    logic [10:0] r_width;
    logic [15:0] r_height;
    logic [CW-1:0] r_col;
    logic [15:0] r_row;
    hmng_pkg::t_state r_state, n_state;

    // Line stores: previous row and the row before it.
    logic [SW-1:0] prev_mem [hmng_pkg::MAX_WIDTH];
    logic [SW-1:0] old_mem [hmng_pkg::MAX_WIDTH];
    logic [SW-1:0] r_prev_x, r_prev_xr, r_old_x, r_old_xl;

    logic [CW-1:0] r_x;
    logic [15:0] r_z;
    logic [SW-1:0] r_s;
    logic r_two;        // two results for this pixel
    logic r_has_up;     // result for row z-1 exists
    logic r_interior;
    logic r_last2;

    logic [11:0] eff_w;
    logic [15:0] eff_h;
    always_comb begin
        eff_w = {1'b0, r_width};
        if (r_width == 11'd0) eff_w = 12'd1;
        if (r_width > 11'(hmng_pkg::MAX_WIDTH)) eff_w = 12'(hmng_pkg::MAX_WIDTH);
        eff_h = (r_height == 16'd0) ? 16'd1 : r_height;
    end

    // Wrap counters that lie beyond the current size.
    logic [CW-1:0] cur_x;
    logic [15:0] cur_z;
    always_comb begin
        cur_x = r_col;
        cur_z = r_row;
        if ({2'b0, r_col} >= eff_w) begin
            cur_x = '0;
            cur_z = r_row + 16'd1;
        end
        if (cur_z >= eff_h) cur_z = '0;
    end

    logic accept_in;
    assign o_stall = (r_state != hmng_pkg::ST_IDLE);
    assign accept_in = i_valid && !o_stall;

    logic [CW-1:0] xr, xl;
    assign xr = cur_x + CW'(1);
    assign xl = cur_x - CW'(1);

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_prev_x  <= prev_mem[cur_x];
            r_prev_xr <= prev_mem[xr];
            r_old_xl  <= old_mem[xl];
        end
        if (r_state == hmng_pkg::ST_READ) begin
            old_mem[r_x]  <= r_prev_x;
            prev_mem[r_x] <= r_s;
        end
    end
    // old[x] is needed too; it is the second read of the older store in the accept cycle.
    always_ff @(posedge i_clk) begin
        if (accept_in) r_old_x <= old_mem[cur_x];
    end

    // Vector pieces, registered after the read.
    logic signed [11:0] dx, dz;
    assign dx = $signed({2'b0, r_old_xl}) - $signed({2'b0, r_prev_xr});
    assign dz = $signed({2'b0, r_old_x}) - $signed({2'b0, r_s});
    logic signed [11:0] r_dx, r_dz;

    // Bit-serial integer square root of 256*(dx^2+8100+dz^2) (< 2^29).
    logic [31:0] r_rem, r_res, r_bit;
    logic [31:0] sq;
    assign sq = ({8'b0, 24'(32'($signed(dx) * $signed(dx))) } + 32'd8100
                + 32'($signed(dz) * $signed(dz))) << 8;
    logic [31:0] rb;
    assign rb = r_res + r_bit;

    // Shared restoring divider: 131072*|v| / L16, three components.
    logic [1:0] r_comp;
    logic [16:0] r_len;
    logic [29:0] r_num;      // numerator being shifted out
    logic [17:0] r_prem;     // partial remainder
    logic [4:0] r_cnt;
    logic [15:0] r_q [3];
    logic [2:0] r_neg;
    logic [17:0] pr_a, pr_b, pr_c;
    logic [29:0] nm_a;
    logic [15:0] qbits;
    always_comb begin
        pr_a = r_prem; nm_a = r_num; qbits = r_q[r_comp];
        for (int k = 0; k < 6; k++) begin
            pr_b = {pr_a[16:0], nm_a[29]};
            nm_a = {nm_a[28:0], 1'b0};
            if (pr_b >= {1'b0, r_len}) begin
                pr_c = pr_b - {1'b0, r_len};
                qbits = {qbits[14:0], 1'b1};
            end else begin
                pr_c = pr_b;
                qbits = {qbits[14:0], 1'b0};
            end
            pr_a = pr_c;
        end
    end

    logic out_free;
    assign out_free = !o_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            hmng_pkg::ST_IDLE: if (accept_in) n_state = hmng_pkg::ST_READ;
            hmng_pkg::ST_READ: begin
                if (!r_has_up && !r_two) n_state = hmng_pkg::ST_IDLE;
                else if (r_interior) n_state = hmng_pkg::ST_ROOT;
                else n_state = hmng_pkg::ST_OUT1;
            end
            hmng_pkg::ST_ROOT: if (r_bit == 32'd0) n_state = hmng_pkg::ST_DIV;
            hmng_pkg::ST_DIV:
                if (r_cnt == 5'd4 && r_comp == 2'd2) n_state = hmng_pkg::ST_OUT1;
            // A one-row frame has no row above, so its single result goes out here.
            hmng_pkg::ST_OUT1: if (out_free)
                n_state = (r_two && r_has_up) ? hmng_pkg::ST_OUT2 : hmng_pkg::ST_IDLE;
            hmng_pkg::ST_OUT2: if (out_free) n_state = hmng_pkg::ST_IDLE;
            default: n_state = hmng_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hmng_pkg::ST_IDLE;
            r_width <= 11'd1024;
            r_height <= 16'd1024;
            r_col <= '0;
            r_row <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == hmng_pkg::REG_WIDTH) r_width <= i_cfg_data[10:0];
            if (i_cfg_we && i_cfg_index == hmng_pkg::REG_HEIGHT) r_height <= i_cfg_data;
            if (accept_in) begin
                if ({2'b0, cur_x} + 12'd1 >= eff_w) begin
                    r_col <= '0;
                    r_row <= (cur_z + 16'd1 >= eff_h) ? 16'd0 : cur_z + 16'd1;
                end else begin
                    r_col <= cur_x + CW'(1);
                    r_row <= cur_z;
                end
            end
            if ((r_state == hmng_pkg::ST_OUT1 || r_state == hmng_pkg::ST_OUT2) && out_free)
                o_valid <= 1'b1;
            else if (out_free)
                o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_x <= cur_x;
            r_z <= cur_z;
            r_s <= SW'({2'b0, i_red} + {2'b0, i_green} + {2'b0, i_blue});
            r_has_up <= (cur_z != 16'd0);
            r_two <= (cur_z == eff_h - 16'd1);
            r_last2 <= ({2'b0, cur_x} == eff_w - 12'd1);
            r_interior <= (cur_x != '0) && ({2'b0, cur_x} + 12'd2 <= eff_w)
                          && (cur_z >= 16'd2);
        end
        if (r_state == hmng_pkg::ST_READ) begin
            r_dx <= dx;
            r_dz <= dz;
            r_rem <= sq;
            r_res <= '0;
            r_bit <= 32'd1 << 30;
        end
        if (r_state == hmng_pkg::ST_ROOT && r_bit != 32'd0) begin
            if (r_rem >= rb) begin
                r_rem <= r_rem - rb;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (r_state == hmng_pkg::ST_ROOT && r_bit == 32'd0) begin
            r_len <= r_res[16:0];
            r_comp <= 2'd0;
            r_cnt <= '0;
            r_prem <= '0;
            r_num <= {r_dx[11] ? 11'(-r_dx) : 11'(r_dx), 19'b0} >> 2;
            r_neg <= {r_dz[11], 1'b0, r_dx[11]};
        end
        if (r_state == hmng_pkg::ST_DIV) begin
            r_q[r_comp] <= qbits;
            if (r_cnt == 5'd4) begin
                r_cnt <= '0;
                r_prem <= '0;
                r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                r_num <= {(r_comp == 2'd0) ? 11'd90 :
                          (r_dz[11] ? 11'(-r_dz) : 11'(r_dz)), 19'b0} >> 2;
            end else begin
                r_cnt <= r_cnt + 5'd1;
                r_prem <= pr_a;
                r_num <= nm_a;
            end
        end
        if ((r_state == hmng_pkg::ST_OUT1 || r_state == hmng_pkg::ST_OUT2) && out_free) begin
            o_column <= r_x;
            if (r_state == hmng_pkg::ST_OUT1 && r_has_up) begin
                o_row <= r_z - 16'd1;
                o_last <= 1'b0;
                if (r_interior) begin
                    o_is_border <= 1'b0;
                    o_normal_x <= r_neg[0] ? -r_q[0] : r_q[0];
                    o_normal_y <= r_q[1];
                    o_normal_z <= r_neg[2] ? -r_q[2] : r_q[2];
                end else begin
                    o_is_border <= 1'b1;
                    o_normal_x <= '0;
                    o_normal_y <= hmng_pkg::BORDER_Y;
                    o_normal_z <= '0;
                end
            end else begin
                o_row <= r_z;
                o_last <= r_last2;
                o_is_border <= 1'b1;
                o_normal_x <= '0;
                o_normal_y <= hmng_pkg::BORDER_Y;
                o_normal_z <= '0;
            end
        end
    end

    ap_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != hmng_pkg::ST_IDLE) |-> !accept_in)
        else $error("pixel taken while busy");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped under stall");
    ap_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hmng_pkg::ST_DIV) |-> (r_bit == 32'd0))
        else $error("divide before root done");
endmodule

// File: verif/height_map_normal_generator_core_tb.sv
`timescale 1ns / 1ps
// Testbench for the height-map normal generator.
// Pixels stream in as whole frames, one frame size per phase, and every normal
// that comes out is compared field by field with a predictor kept in this file.
// The frame size changes only while the block is idle and between frames, so
// the line stores are always written by the current frame before they are read.
module height_map_normal_generator_core_tb;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 1000000;
    // Settling time before a register write and at the end of the run.
    localparam int DRAIN_CYCLES = 80;
    localparam logic signed [15:0] BORDER_NY = hmng_pkg::BORDER_Y;

    typedef struct packed {
        logic [9:0]         column;
        logic [15:0]        row;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               border;
        logic               last;
    } t_normal;

    // One row of the directed part. n_known < 0 means the expectation comes
    // from the predictor; otherwise n_known results (0 or 1) are typed in.
    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int         n_known;
        t_normal    known;
    } t_pixel_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic        o_valid;
    logic        i_stall;
    logic [9:0]  o_column;
    logic [15:0] o_row;
    logic signed [15:0] o_normal_x;
    logic signed [15:0] o_normal_y;
    logic signed [15:0] o_normal_z;
    logic        o_is_border;
    logic        o_last;

    height_map_normal_generator_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_red      (i_red),
        .i_green    (i_green),
        .i_blue     (i_blue),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_column   (o_column),
        .o_row      (o_row),
        .o_normal_x (o_normal_x),
        .o_normal_y (o_normal_y),
        .o_normal_z (o_normal_z),
        .o_is_border(o_is_border),
        .o_last     (o_last)
    );

    // Predictor state: its own copy of the registers, counters and line stores.
    logic [10:0] frame_width_reg;
    logic [15:0] frame_height_reg;
    logic [9:0]  sums_prev_row [hmng_pkg::MAX_WIDTH];
    logic [9:0]  sums_older_row[hmng_pkg::MAX_WIDTH];
    int unsigned pix_col;
    int unsigned pix_row;

    t_normal pending_normals[$];
    int      mismatches;
    int      normals_seen;
    int      pixels_sent;
    int      cycle_count;
    bit      idling_on;
    int      stall_left;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic void expect_normal(t_normal n);
        pending_normals = {pending_normals, n};
    endfunction

    function automatic int unsigned floor_root(int unsigned v);
        int unsigned res;
        int unsigned bit_w;
        res   = 0;
        bit_w = 32'h4000_0000;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // Q3.13 component: 131072 * v / L16, truncated toward zero.
    function automatic logic signed [15:0] to_q13(int v, int unsigned len16);
        longint mag;
        longint q;
        mag = (v < 0) ? -v : v;
        q   = (mag * 131072) / len16;
        return (v < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic t_normal border_normal(int unsigned x, int unsigned z, bit is_last);
        t_normal n;
        n.column = 10'(x);
        n.row    = 16'(z);
        n.nx     = 16'sd0;
        n.ny     = BORDER_NY;
        n.nz     = 16'sd0;
        n.border = 1'b1;
        n.last   = is_last;
        return n;
    endfunction

    // Advances the predictor by one accepted pixel and returns the normals
    // that this pixel releases.
    task automatic predict_normals(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, output t_normal res[2],
                                   output int n_res);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned z;
        int unsigned s;
        int          dx;
        int          dz;
        int unsigned len16;
        w = (frame_width_reg < 1) ? 1 :
            ((frame_width_reg > hmng_pkg::MAX_WIDTH) ? hmng_pkg::MAX_WIDTH : frame_width_reg);
        h = (frame_height_reg < 1) ? 1 : frame_height_reg;
        n_res = 0;
        if (pix_col >= w) begin
            pix_col = 0;
            pix_row++;
        end
        if (pix_row >= h) pix_row = 0;
        x = pix_col;
        z = pix_row;
        s = r + g + b;

        // A pixel completes the normal of the pixel just above it.
        if (z >= 1) begin
            if (x >= 1 && x + 2 <= w && z >= 2) begin
                dx    = int'(sums_older_row[x - 1]) - int'(sums_prev_row[x + 1]);
                dz    = int'(sums_older_row[x]) - int'(s);
                len16 = floor_root((dx * dx + 8100 + dz * dz) * 256);
                res[n_res].column = 10'(x);
                res[n_res].row    = 16'(z - 1);
                res[n_res].nx     = to_q13(dx, len16);
                res[n_res].ny     = to_q13(90, len16);
                res[n_res].nz     = to_q13(dz, len16);
                res[n_res].border = 1'b0;
                res[n_res].last   = 1'b0;
            end else begin
                res[n_res] = border_normal(x, z - 1, 1'b0);
            end
            n_res++;
        end
        // The bottom row is all border and goes out as it arrives.
        if (z == h - 1) begin
            res[n_res] = border_normal(x, z, x == w - 1);
            n_res++;
        end

        sums_older_row[x] = sums_prev_row[x];
        sums_prev_row[x]  = 10'(s);
        pix_col++;
        if (pix_col >= w) begin
            pix_col = 0;
            pix_row++;
            if (pix_row >= h) pix_row = 0;
        end
    endtask

    // Sends one pixel, optionally after an idle burst, and waits for the beat.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input int n_known,
                              input t_normal known);
        t_normal res[2];
        int      n_res;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do @(posedge i_clk); while (o_stall);
        predict_normals(r, g, b, res, n_res);
        pixels_sent++;
        if (n_known >= 0) begin
            if (n_known > 0) expect_normal(known);
        end else begin
            for (int k = 0; k < n_res; k++) expect_normal(res[k]);
        end
    endtask

    // Waits until the block has delivered everything and gone quiet.
    task automatic drain_block();
        i_valid <= 1'b0;
        wait (pending_normals.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame_size(input logic [10:0] w, input logic [15:0] h);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= hmng_pkg::REG_WIDTH;
        i_cfg_data  <= {5'd0, w};
        @(posedge i_clk);
        i_cfg_index <= hmng_pkg::REG_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_width_reg  = w;
        frame_height_reg = h;
    endtask

    // One whole frame of random content. The style of the frame picks between
    // plain random bytes, a smooth surface and hard black/white steps.
    task automatic send_random_frame(input int unsigned w, input int unsigned h);
        int         style;
        logic [7:0] base;
        logic [7:0] ch[3];
        style = $urandom_range(0, 2);
        base  = 8'($urandom);
        for (int unsigned p = 0; p < w * h; p++) begin
            for (int c = 0; c < 3; c++) begin
                case (style)
                    0: begin
                        ch[c] = 8'($urandom);
                    end
                    1: begin
                        ch[c] = base + 8'($urandom_range(0, 6)) - 8'd3;
                    end
                    default: begin
                        ch[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    end
                endcase
            end
            if (style == 1) base = base + 8'($urandom_range(0, 4)) - 8'd2;
            send_pixel(ch[0], ch[1], ch[2], -1, '0);
        end
    endtask

    // Output stall: random bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Every accepted beat is checked against the oldest pending normal.
    always @(posedge i_clk) begin
        t_normal got;
        t_normal want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_column, o_row, o_normal_x, o_normal_y, o_normal_z,
                    o_is_border, o_last};
            normals_seen++;
            if (pending_normals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected normal at (%0d,%0d): %p", o_column, o_row, got);
            end else begin
                want = pending_normals.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d normals still pending",
                     cycle_count, pending_normals.size());
            $display("FAIL");
            $finish;
        end
    end

    // Directed part. The 3x3 frame has a single interior pixel at (1,1) that
    // sees the steepest possible slope along z; its normal comes from the
    // predictor. Rows 0 and 1 of that frame have known results: nothing for
    // the top row, then the top row's border normals. The 1x1 frames give a
    // border normal flagged as the last of the frame on every pixel.
    t_pixel_row dir_rows[11] = '{
        '{8'hFF, 8'hFF, 8'hFF, 0, '0},
        '{8'h00, 8'h00, 8'h00, 0, '0},
        '{8'h01, 8'h02, 8'h04, 0, '0},
        '{8'h80, 8'h40, 8'h20, 1, '{10'd0, 16'd0, 16'sd0, BORDER_NY, 16'sd0, 1'b1, 1'b0}},
        '{8'h07, 8'h07, 8'h07, 1, '{10'd1, 16'd0, 16'sd0, BORDER_NY, 16'sd0, 1'b1, 1'b0}},
        '{8'h00, 8'h00, 8'h00, 1, '{10'd2, 16'd0, 16'sd0, BORDER_NY, 16'sd0, 1'b1, 1'b0}},
        '{8'hFF, 8'h00, 8'h00, -1, '0},
        '{8'hFF, 8'hFF, 8'hFF, -1, '0},
        '{8'h00, 8'hFF, 8'h00, -1, '0},
        '{8'hFF, 8'hFF, 8'hFF, 1, '{10'd0, 16'd0, 16'sd0, BORDER_NY, 16'sd0, 1'b1, 1'b1}},
        '{8'h00, 8'h00, 8'h55, 1, '{10'd0, 16'd0, 16'sd0, BORDER_NY, 16'sd0, 1'b1, 1'b1}}
    };

    // Random phases as {width register, height register, frames}. Zero
    // registers act as 1.
    int unsigned phases[8][3] = '{
        '{5, 4, 1}, '{17, 7, 1}, '{2, 9, 1}, '{1, 12, 1}, '{9, 2, 1},
        '{0, 0, 6}, '{32, 10, 1}, '{6, 5, 1}
    };

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= hmng_pkg::REG_WIDTH;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_red       <= '0;
        i_green     <= '0;
        i_blue      <= '0;
        mismatches   = 0;
        normals_seen = 0;
        pixels_sent  = 0;
        cycle_count  = 0;
        idling_on    = 1'b1;
        frame_width_reg  = 11'd1024;
        frame_height_reg = 16'd1024;
        pix_col = 0;
        pix_row = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_frame_size(11'd3, 16'd3);
        for (int i = 0; i < 11; i++) begin
            if (i == 9) begin
                drain_block();
                set_frame_size(11'd1, 16'd1);
            end
            send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b,
                       dir_rows[i].n_known, dir_rows[i].known);
        end
        drain_block();

        for (int ph = 0; ph < 8; ph++) begin
            int unsigned w;
            int unsigned h;
            // The closing phase runs with neither side idling.
            idling_on = (ph == 7) ? 1'b0 : ($urandom_range(0, 4) != 0);
            set_frame_size(11'(phases[ph][0]), 16'(phases[ph][1]));
            w = (phases[ph][0] < 1) ? 1 :
                ((phases[ph][0] > hmng_pkg::MAX_WIDTH) ? hmng_pkg::MAX_WIDTH : phases[ph][0]);
            h = (phases[ph][1] < 1) ? 1 : phases[ph][1];
            for (int f = 0; f < phases[ph][2]; f++) send_random_frame(w, h);
            drain_block();
        end

        $display("Sent %0d pixels in frames from 1x1 up to 32 wide, checked %0d normals",
                 pixels_sent, normals_seen);
        $display("with random input gaps and output stalls; %0d mismatches", mismatches);
        if (mismatches == 0 && pending_normals.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: filelist.f
hdl/hmng_pkg.sv
hdl/height_map_normal_generator_core.sv
verif/height_map_normal_generator_core_tb.sv
